/* rtl/core/ray_box_nearest_pick_macros.svh */
// Assertion macros shared by the ray box pick modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef RAY_BOX_NEAREST_PICK_MACROS_SVH
`define RAY_BOX_NEAREST_PICK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBNP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RBNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/core/rbnp_pkg.sv */
// Shared types and constants for the ray box nearest pick block.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package rbnp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W = 32;
	localparam int DIST_W = 31;
	localparam int ADDR_W = 5;
	// Running entry and exit hold the quotient range plus the unbounded marks.
	localparam int T_W = 42;
	localparam logic signed [T_W-1:0] T_INF = 42'sd1 <<< 40;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X = 3'd3;
	localparam logic [2:0] REG_DIR_Y = 3'd4;
	localparam logic [2:0] REG_DIR_Z = 3'd5;

	typedef struct packed {
		logic [31:0] entity_handle;
		logic entity_valid;
		logic has_transform;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
		logic last_entity;
	} ent_word_t;

	typedef struct packed {
		logic hit_found;
		logic [31:0] nearest_handle;
		logic [30:0] nearest_distance;
	} res_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AXIS,
		S_DIV_LO,
		S_DIV_HI,
		S_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic zero_chk;
		logic div_start;
		logic div_hi;
		logic take_lo;
		logic take_hi;
		logic upd;
		logic emit;
		logic [1:0] axis;
	} ctrl_cmd_t;

	typedef struct packed {
		logic item_valid;
		logic item_last;
		logic dir_zero;
		logic miss;
		logic div_done;
		logic out_busy;
	} ctrl_stat_t;

endpackage

/* rtl/core/rbnp_div.sv */
// Iterative signed divider for the slab quotients, one quotient bit a cycle.
// Depends on rbnp_pkg; used by rbnp_dp.
`timescale 1ns / 1ps
module rbnp_div #(
	parameter int FRAC_BITS = rbnp_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [34:0] num,
	input logic signed [32:0] den,
	output logic done,
	output logic signed [31:0] quot
);
	import rbnp_pkg::*;

	localparam int DW = 34 + FRAC_BITS;
	localparam int CW = $clog2(DW);

	logic running_q;
	logic done_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [DW-1:0] quo_q;
	logic [34:0] num_mag;
	logic [32:0] den_mag;
	logic [33:0] trial;
	logic [33:0] diff;

	assign num_mag = num[34] ? -num : num;
	assign den_mag = den[32] ? -den : den;
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !running_q) begin
				running_q <= 1'b1;
				cnt_q <= CW'(DW - 1);
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					running_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !running_q) begin
			rem_q <= '0;
			den_q <= den_mag;
			quo_q <= {num_mag[33:0], {FRAC_BITS{1'b0}}};
			neg_q <= num[34] ^ den[32];
		end else if (running_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	// Saturate the truncated quotient to the signed 32-bit range.
	always_comb begin
		if (!neg_q) begin
			if (quo_q > DW'(32'h7FFF_FFFF)) quot = 32'sh7FFF_FFFF;
			else quot = quo_q[31:0];
		end else begin
			if (quo_q > DW'(33'h0_8000_0000)) quot = 32'sh8000_0000;
			else quot = -quo_q[31:0];
		end
	end

	assign done = done_q;

endmodule

/* rtl/core/rbnp_dp.sv */
// Datapath: ray registers, item capture, box bounds, slab interval and best hit.
// Depends on rbnp_pkg, rbnp_div and the assertion macro header.
`timescale 1ns / 1ps
`include "ray_box_nearest_pick_macros.svh"
module rbnp_dp #(
	parameter int FRAC_BITS = rbnp_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rbnp_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	input rbnp_pkg::ent_word_t ent_word,
	output logic res_valid,
	input logic res_stall,
	output rbnp_pkg::res_word_t res_word,
	input rbnp_pkg::ctrl_cmd_t cmd,
	output rbnp_pkg::ctrl_stat_t stat
);
	import rbnp_pkg::*;

	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	ent_word_t item_q;
	logic signed [T_W-1:0] tmin_q;
	logic signed [T_W-1:0] tmax_q;
	logic signed [31:0] t_lo_q;
	logic miss_q;
	logic [DIST_W-1:0] best_q;
	logic [31:0] best_handle_q;
	logic any_hit_q;
	logic res_valid_q;
	res_word_t res_q;

	logic [2:0] reg_idx;
	logic signed [31:0] c_sel, s_sel, o_sel, d_sel;
	logic signed [33:0] c2, e2, lo2, hi2, o2;
	logic signed [34:0] num;
	logic signed [32:0] den;
	logic div_done;
	logic signed [31:0] quot;
	logic signed [T_W-1:0] t1, t2, tmin_n, tmax_n, hit_t;
	logic hit, better;

	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				dir_q[i] <= '0;
			end
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ORIGIN_X: org_q[0] <= pwdata;
				REG_ORIGIN_Y: org_q[1] <= pwdata;
				REG_ORIGIN_Z: org_q[2] <= pwdata;
				REG_DIR_X: dir_q[0] <= pwdata;
				REG_DIR_Y: dir_q[1] <= pwdata;
				REG_DIR_Z: dir_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ORIGIN_X: prdata = org_q[0];
			REG_ORIGIN_Y: prdata = org_q[1];
			REG_ORIGIN_Z: prdata = org_q[2];
			REG_DIR_X: prdata = dir_q[0];
			REG_DIR_Y: prdata = dir_q[1];
			REG_DIR_Z: prdata = dir_q[2];
			default: prdata = '0;
		endcase
	end

	always_comb begin
		case (cmd.axis)
			2'd0: begin
				c_sel = item_q.center_x;
				s_sel = item_q.scale_x;
				o_sel = org_q[0];
				d_sel = dir_q[0];
			end
			2'd1: begin
				c_sel = item_q.center_y;
				s_sel = item_q.scale_y;
				o_sel = org_q[1];
				d_sel = dir_q[1];
			end
			default: begin
				c_sel = item_q.center_z;
				s_sel = item_q.scale_z;
				o_sel = org_q[2];
				d_sel = dir_q[2];
			end
		endcase
	end

	// Bounds are kept at twice their value so that the half extent stays exact.
	always_comb begin
		if (item_q.has_transform) begin
			c2 = {{1{c_sel[31]}}, c_sel, 1'b0};
			e2 = s_sel[31] ? -{{2{s_sel[31]}}, s_sel} : {{2{s_sel[31]}}, s_sel};
		end else begin
			c2 = '0;
			e2 = 34'sd1 <<< FRAC_BITS;
		end
		lo2 = c2 - e2;
		hi2 = c2 + e2;
		o2 = {{1{o_sel[31]}}, o_sel, 1'b0};
		num = cmd.div_hi ? ({hi2[33], hi2} - {o2[33], o2}) : ({lo2[33], lo2} - {o2[33], o2});
		den = {d_sel, 1'b0};
	end

	rbnp_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(num),
		.den(den),
		.done(div_done),
		.quot(quot)
	);

	always_comb begin
		t1 = T_W'(t_lo_q);
		t2 = T_W'(quot);
		if (t1 > t2) begin
			t1 = T_W'(quot);
			t2 = T_W'(t_lo_q);
		end
		tmin_n = (t1 > tmin_q) ? t1 : tmin_q;
		tmax_n = (t2 < tmax_q) ? t2 : tmax_q;
		hit = !miss_q && (tmax_q >= 0);
		hit_t = (tmin_q >= 0) ? tmin_q : tmax_q;
		better = hit && (hit_t < $signed({{(T_W-DIST_W){1'b0}}, best_q}));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= ent_word;
		if (cmd.take_lo) t_lo_q <= quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmin_q <= -T_INF;
			tmax_q <= T_INF;
			miss_q <= 1'b0;
			best_q <= DIST_MAX;
			best_handle_q <= '0;
			any_hit_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cmd.load) begin
				tmin_q <= -T_INF;
				tmax_q <= T_INF;
				miss_q <= 1'b0;
			end
			if (cmd.zero_chk && (o2 < lo2 || o2 > hi2)) miss_q <= 1'b1;
			if (cmd.take_hi) begin
				tmin_q <= tmin_n;
				tmax_q <= tmax_n;
				if (tmin_n > tmax_n) miss_q <= 1'b1;
			end
			if (cmd.upd && better) begin
				best_q <= hit_t[DIST_W-1:0];
				best_handle_q <= item_q.entity_handle;
				any_hit_q <= 1'b1;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
				res_q.hit_found <= any_hit_q;
				res_q.nearest_handle <= best_handle_q;
				res_q.nearest_distance <= best_q;
				best_q <= DIST_MAX;
				best_handle_q <= '0;
				any_hit_q <= 1'b0;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_word = res_q;

	always_comb begin
		stat.item_valid = item_q.entity_valid;
		stat.item_last = item_q.last_entity;
		stat.dir_zero = (d_sel == '0);
		stat.miss = miss_q;
		stat.div_done = div_done;
		stat.out_busy = res_valid_q && res_stall;
	end

	`RBNP_ASSERT_NEXT(a_emit_shows, clk, arst_n, cmd.emit, res_valid)
	`RBNP_ASSERT_NEXT(a_emit_clears, clk, arst_n, cmd.emit, best_q == DIST_MAX && !any_hit_q)
	`RBNP_ASSERT_NOW(a_hit_nearer, clk, arst_n, any_hit_q, best_q != DIST_MAX)
	`RBNP_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit, !(res_valid_q && res_stall))

endmodule

/* rtl/core/rbnp_ctrl.sv */
// Controller: sequences capture, per-axis slab divisions, update and result.
// Depends on rbnp_pkg; drives rbnp_dp through command and status structs.
`timescale 1ns / 1ps
module rbnp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic ent_valid,
	output logic ent_stall,
	input rbnp_pkg::ctrl_stat_t stat,
	output rbnp_pkg::ctrl_cmd_t cmd
);
	import rbnp_pkg::*;

	state_t state_q, state_n;
	logic [1:0] axis_q, axis_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= '0;
		end else begin
			state_q <= state_n;
			axis_q <= axis_n;
		end
	end

	always_comb begin
		state_n = state_q;
		axis_n = axis_q;
		cmd = '0;
		cmd.axis = axis_q;
		ent_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				ent_stall = 1'b0;
				if (ent_valid) begin
					cmd.load = 1'b1;
					axis_n = '0;
					state_n = S_AXIS;
				end
			end
			S_AXIS: begin
				if (!stat.item_valid) state_n = S_DONE;
				else if (stat.miss || axis_q == 2'd3) state_n = S_UPD;
				else if (stat.dir_zero) begin
					cmd.zero_chk = 1'b1;
					axis_n = axis_q + 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					state_n = S_DIV_LO;
				end
			end
			S_DIV_LO: begin
				if (stat.div_done) begin
					cmd.take_lo = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_hi = 1'b1;
					state_n = S_DIV_HI;
				end
			end
			S_DIV_HI: begin
				if (stat.div_done) begin
					cmd.take_hi = 1'b1;
					axis_n = axis_q + 1'b1;
					state_n = S_AXIS;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_n = S_DONE;
			end
			S_DONE: begin
				if (!stat.item_last) state_n = S_IDLE;
				else if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

endmodule

/* rtl/core/ray_box_nearest_pick.sv */
// Ray pick over a stream of entity boxes: keeps the nearest slab-test hit.
// Usage: write the ray origin and direction (Q16.16) over the APB port while idle,
// then send entity words on ent_valid/ent_stall. Each valid word is turned into
// an axis-aligned box and slab-tested against the ray; the strictly nearest hit
// is kept. The word marked last_entity produces one result word on
// res_valid/res_stall (found flag, handle, distance) and clears the running best.
// Throughput: one word at a time; ent_stall is low only in the idle state. A
// valid word is tested axis by axis: an axis with a zero direction gets a bounds
// check, an axis with a nonzero one runs the shared one-bit-a-cycle divider
// twice, for the low and the high slab plane. An axis that misses ends the test
// early. A skipped word skips the axis tests and goes to the done state.
// A result word is loaded into an output register from the done state after the
// last word's test completes; new entity words are accepted while it waits.
// If a further last word finishes while that result is still stalled, the block
// holds until the receiver takes it.
// Reset clears the ray registers to zero, the best hit to "none" and the channels.
`timescale 1ns / 1ps
module ray_box_nearest_pick #(
	parameter int FRAC_BITS = rbnp_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [rbnp_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic ent_valid,
	output logic ent_stall,
	input rbnp_pkg::ent_word_t ent_word,
	output logic res_valid,
	input logic res_stall,
	output rbnp_pkg::res_word_t res_word
);
	import rbnp_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_stat_t stat;

	assign pready = 1'b1;

	rbnp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.ent_valid(ent_valid),
		.ent_stall(ent_stall),
		.stat(stat),
		.cmd(cmd)
	);

	rbnp_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.ent_word(ent_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word),
		.cmd(cmd),
		.stat(stat)
	);

endmodule

/* dv/tb_top.sv */
// Testbench for ray_box_nearest_pick: drives entity words and APB ray setup,
// predicts each query result with a slab-test model. Depends on rbnp_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
	import rbnp_pkg::*;

	localparam int FB = 16;
	localparam longint LIMIT = 3000000;

	class pick_scoreboard;
		longint ray_o[3];
		longint ray_d[3];
		longint best_dist;
		logic [31:0] best_hdl;
		bit found;
		res_word_t pending[$];
		int errors;

		function new();
			errors = 0;
			for (int a = 0; a < 3; a++) begin
				ray_o[a] = 0;
				ray_d[a] = 0;
			end
			clear_best();
		endfunction

		function void clear_best();
			best_dist = 64'h7FFFFFFF;
			best_hdl = 0;
			found = 0;
		endfunction

		function longint slab_div(longint num2, longint den2);
			longint q;
			q = (num2 * (64'sd1 << FB)) / den2;
			if (q < -64'sd2147483648) q = -64'sd2147483648;
			if (q > 64'sd2147483647) q = 64'sd2147483647;
			return q;
		endfunction

		function void note_entity(ent_word_t w);
			longint lo2[3], hi2[3], c[3], s[3], e2, tmin, tmax, t1, t2, tmp, o2, d2, hit_t;
			bit hit;
			res_word_t r;
			c[0] = longint'(w.center_x); c[1] = longint'(w.center_y);
			c[2] = longint'(w.center_z);
			s[0] = longint'(w.scale_x); s[1] = longint'(w.scale_y);
			s[2] = longint'(w.scale_z);
			if (w.entity_valid) begin
				for (int a = 0; a < 3; a++) begin
					e2 = w.has_transform ? (s[a] < 0 ? -s[a] : s[a]) : (64'sd1 << FB);
					lo2[a] = (w.has_transform ? 2 * c[a] : 0) - e2;
					hi2[a] = (w.has_transform ? 2 * c[a] : 0) + e2;
				end
				tmin = -(64'sd1 << 40);
				tmax = 64'sd1 << 40;
				hit = 1;
				for (int a = 0; a < 3 && hit; a++) begin
					o2 = 2 * ray_o[a];
					d2 = 2 * ray_d[a];
					if (d2 != 0) begin
						t1 = slab_div(lo2[a] - o2, d2);
						t2 = slab_div(hi2[a] - o2, d2);
						if (t1 > t2) begin
							tmp = t1; t1 = t2; t2 = tmp;
						end
						if (t1 > tmin) tmin = t1;
						if (t2 < tmax) tmax = t2;
						if (tmin > tmax) hit = 0;
					end else if (o2 < lo2[a] || o2 > hi2[a]) begin
						hit = 0;
					end
				end
				if (hit && tmax < 0) hit = 0;
				hit_t = (tmin >= 0) ? tmin : tmax;
				if (hit && hit_t < best_dist) begin
					best_dist = hit_t;
					best_hdl = w.entity_handle;
					found = 1;
				end
			end
			if (w.last_entity) begin
				r.hit_found = found;
				r.nearest_handle = best_hdl;
				r.nearest_distance = best_dist[30:0];
				pending = {pending, r};
				clear_best();
			end
		endfunction

		task check_result(res_word_t got);
			res_word_t exp_r;
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing pending");
				return;
			end
			exp_r = pending.pop_front();
			if (got.hit_found !== exp_r.hit_found)
				report_mismatch($sformatf("hit_found %0b want %0b", got.hit_found,
					exp_r.hit_found));
			if (got.nearest_handle !== exp_r.nearest_handle)
				report_mismatch($sformatf("nearest_handle %h want %h",
					got.nearest_handle, exp_r.nearest_handle));
			if (got.nearest_distance !== exp_r.nearest_distance)
				report_mismatch($sformatf("nearest_distance %h want %h",
					got.nearest_distance, exp_r.nearest_distance));
		endtask

		task report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic ent_valid = 0;
	logic ent_stall;
	ent_word_t ent_word = '0;
	logic res_valid;
	logic res_stall = 0;
	res_word_t res_word;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycles = 0;
	pick_scoreboard sb;

	ray_box_nearest_pick dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.ent_valid(ent_valid), .ent_stall(ent_stall), .ent_word(ent_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
		if (arst_n && res_valid && !res_stall) sb.check_result(res_word);
	end

	// The receiver's stall changes at the falling edge only.
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx < 6) begin
			if (idx < 3) sb.ray_o[idx] = longint'(signed'(val));
			else sb.ray_d[idx - 3] = longint'(signed'(val));
		end
	endtask

	task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
		write_reg(REG_ORIGIN_X, ox); write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz); write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy); write_reg(REG_DIR_Z, dz);
	endtask

	task automatic send_entity(ent_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			ent_valid <= 0;
			@(negedge clk);
		end
		ent_word <= w;
		ent_valid <= 1;
		do @(posedge clk); while (ent_stall);
		sb.note_entity(w);
		@(negedge clk);
		ent_valid <= 0;
	endtask

	// Wait for all results, then let a skipped-or-tested word finish inside the block.
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'h80000000;
			2: return 32'h7FFFFFFF;
			default: return 32'(int'($urandom_range(20 << 16)) - (10 << 16));
		endcase
	endfunction

	function automatic ent_word_t rand_entity(bit last);
		ent_word_t w;
		w.entity_handle = $urandom();
		w.entity_valid = ($urandom_range(9) != 0);
		w.has_transform = ($urandom_range(5) != 0);
		w.center_x = rand_coord(); w.center_y = rand_coord(); w.center_z = rand_coord();
		w.scale_x = rand_coord(); w.scale_y = rand_coord(); w.scale_z = rand_coord();
		w.last_entity = last;
		return w;
	endfunction

	function automatic ent_word_t mk(logic [31:0] h, bit v, bit x, logic [31:0] c, s, bit l);
		ent_word_t w;
		w.entity_handle = h; w.entity_valid = v; w.has_transform = x;
		w.center_x = c; w.center_y = c; w.center_z = c;
		w.scale_x = s; w.scale_y = s; w.scale_z = s;
		w.last_entity = l;
		return w;
	endfunction

	task automatic random_phase(int n);
		int left;
		left = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) left = $urandom_range(6, 1);
			left--;
			send_entity(rand_entity(left == 0 || i == n - 1));
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: ray along +x from x=-8, unit boxes, ties, miss.
		set_ray(32'hFFF80000, 0, 0, 32'h00010000, 0, 0);
		send_entity(mk(32'h11, 1, 0, 0, 0, 0));
		send_entity(mk(32'h22, 1, 0, 0, 0, 0));
		send_entity(mk(32'h33, 0, 1, 32'h00010000, 32'h00020000, 1));
		send_entity(mk(32'hFFFFFFFF, 1, 1, 32'h00050000, 32'hFFFE0000, 0));
		send_entity(mk(32'h44, 1, 1, 32'h80000000, 32'h7FFFFFFF, 1));
		send_entity(mk(32'h55, 1, 1, 32'h7FFFFFFF, 32'h80000000, 1));
		send_entity(mk(32'h66, 0, 0, 0, 0, 1));
		drain();
		// All directions zero: never a hit even when the origin is inside.
		set_ray(0, 0, 0, 0, 0, 0);
		send_entity(mk(32'h77, 1, 0, 0, 0, 1));
		send_entity(mk(32'h88, 1, 1, 32'h00100000, 32'h00010000, 1));
		drain();
		// Extreme directions force quotient saturation.
		set_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF,
			32'h80000000);
		send_entity(mk(32'h99, 1, 1, 32'h80000000, 32'h7FFFFFFF, 0));
		send_entity(mk(32'hAA, 1, 1, 0, 32'h80000000, 1));
		drain();

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 17 : (p == 1) ? 61 : 0;
			recv_idle_pct = (p == 0) ? 61 : (p == 1) ? 17 : 0;
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(1))
					set_ray(rand_coord(), rand_coord(), rand_coord(),
						$urandom_range(2) ? rand_coord() : 0,
						$urandom_range(2) ? rand_coord() : 0,
						$urandom_range(2) ? rand_coord() : 0);
				else
					set_ray(32'(int'($urandom_range(8 << 16)) - (4 << 16)), 0, 0,
						32'(int'($urandom_range(4 << 16)) - (2 << 16)),
						32'($urandom_range(1 << 16)), 0);
				random_phase(44);
			end
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule
